@@ hw/rtl/jsr_pkg.sv @@
// Shared types and constants of the Jacobi stencil relaxation block.
package jsr_pkg;

  localparam int unsigned CELL_W   = 24;
  localparam int unsigned SUM_W    = 27;
  localparam int unsigned ITER_W   = 16;
  localparam int unsigned GSIZE_W  = 7;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Divide by five: floor(x * RECIP / 2^SHIFT) is exact for every 27-bit sum.
  localparam int unsigned            DIV_SHIFT = 29;
  localparam logic [SUM_W-1:0]       DIV_RECIP = 27'd107374183;

  localparam logic [GSIZE_W-1:0] GSIZE_RST = 7'd64;
  localparam logic [CELL_W-1:0]  THRESH_RST = 24'd0;
  localparam logic [ITER_W-1:0]  MAXIT_RST = 16'd65535;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_MAX_ITER  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [CELL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ITER_W-1:0] iterations;
    logic              hit_limit;
  } rsp_t;

  // Whether a cell lies in the active grid, and which stencil terms it takes from the grid rather than the zero border.
  typedef struct packed {
    logic in_grid;
    logic up;
    logic down;
    logic left;
    logic right;
  } nbr_t;

endpackage

@@ hw/rtl/jsr_bank.sv @@
// One grid bank: one write port and two registered read ports.
module jsr_bank #(
  parameter int unsigned AW = 12
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [jsr_pkg::CELL_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr0_i,
  input  logic [AW-1:0]              raddr1_i,
  output logic [jsr_pkg::CELL_W-1:0] rdata0_o,
  output logic [jsr_pkg::CELL_W-1:0] rdata1_o
);

  logic [jsr_pkg::CELL_W-1:0] mem_q [2**AW];
  logic [jsr_pkg::CELL_W-1:0] rdata0_q;
  logic [jsr_pkg::CELL_W-1:0] rdata1_q;

  // Write one word, read two words through registered outputs
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

@@ hw/rtl/jacobi_stencil_relaxation.sv @@
// Jacobi relaxation block: two grid banks, sweep sequencer and stencil pipeline.
// Load and read words: result strobe in the cycle right after acceptance, one word per cycle.
// Run word: each sweep walks all MAX_N*MAX_N cells on the two read ports of the source bank
//   and then drains; result strobe in the cycle after the last sweep has drained.
// The receiver cannot stall; each result is on rsp_o for exactly one cycle with done_o.
// Reset clears control and sets configuration to its reset values; grid contents stay undefined until loaded.
module jacobi_stencil_relaxation #(
  parameter int unsigned MAX_N = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  jsr_pkg::req_t                    req_i,
  output logic                             done_o,
  output jsr_pkg::rsp_t                    rsp_o,
  input  logic                             cfg_we_i,
  input  logic [jsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [jsr_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned RW = $clog2(MAX_N);
  localparam int unsigned NW = $clog2(MAX_N + 1);
  localparam int unsigned AW = 2 * RW;
  localparam int unsigned PW = 2 * jsr_pkg::SUM_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_e;

  // Configuration registers
  logic [jsr_pkg::GSIZE_W-1:0] grid_size_q;
  logic [jsr_pkg::CELL_W-1:0]  threshold_q;
  logic [jsr_pkg::ITER_W-1:0]  max_iter_q;

  // Sequencer state
  state_e                     state_q;
  logic [RW-1:0]              r_q;
  logic [RW-1:0]              c_q;
  logic                       ph_q;
  logic [jsr_pkg::ITER_W-1:0] iters_q;
  logic [jsr_pkg::CELL_W-1:0] big_q;
  logic                       cur_q;
  logic                       done_q;
  logic                       out_rd_q;
  logic [jsr_pkg::ITER_W-1:0] out_iter_q;
  logic                       out_hit_q;

  // Stencil pipeline
  logic                        p1_v_q;
  jsr_pkg::nbr_t               p1_nbr_q;
  logic [AW-1:0]               p1_addr_q;
  logic [jsr_pkg::CELL_W-1:0]  up_q;
  logic [jsr_pkg::CELL_W-1:0]  down_q;
  logic [jsr_pkg::CELL_W-1:0]  left_q;
  logic                        s1_v_q;
  logic [jsr_pkg::SUM_W-1:0]   sum_q;
  logic [jsr_pkg::CELL_W-1:0]  s1_self_q;
  logic                        s1_in_q;
  logic [AW-1:0]               s1_addr_q;
  logic                        s2_v_q;
  logic [jsr_pkg::CELL_W-1:0]  nv_q;
  logic [jsr_pkg::CELL_W-1:0]  s2_self_q;
  logic                        s2_in_q;
  logic [AW-1:0]               s2_addr_q;

  // Combinational signals
  logic [NW-1:0]              n_act;
  logic [jsr_pkg::ITER_W-1:0] lim_eff;
  logic [jsr_pkg::ITER_W-1:0] iters_n;
  logic                       accept;
  logic                       in_range;
  logic [AW-1:0]              io_addr;
  logic                       load_we;
  logic                       issue1;
  logic                       last_cell;
  logic                       pipe_empty;
  jsr_pkg::nbr_t              nbr;
  logic [AW-1:0]              raddr0;
  logic [AW-1:0]              raddr1;
  logic [jsr_pkg::CELL_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic [jsr_pkg::CELL_W-1:0] src_rd0, src_rd1;
  logic [jsr_pkg::SUM_W-1:0]  sum_d;
  logic [PW-1:0]              prod;
  logic [jsr_pkg::CELL_W-1:0] wr_data;
  logic [AW-1:0]              wr_addr;
  logic [jsr_pkg::CELL_W-1:0] diff;
  logic                       we_a, we_b;

  // Clamp the grid size and the iteration limit
  always_comb begin
    if (grid_size_q == '0) begin
      n_act = NW'(1);
    end else if (32'(grid_size_q) > 32'(MAX_N)) begin
      n_act = NW'(MAX_N);
    end else begin
      n_act = NW'(grid_size_q);
    end
  end

  assign lim_eff = (max_iter_q == '0) ? jsr_pkg::ITER_W'(1) : max_iter_q;
  assign iters_n = iters_q + jsr_pkg::ITER_W'(1);

  // Accept and decode the command word
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(req_i.row) < 32'(MAX_N)) && (32'(req_i.col) < 32'(MAX_N));
  assign io_addr  = {RW'(req_i.row), RW'(req_i.col)};
  assign load_we  = accept && (req_i.mode == jsr_pkg::MODE_LOAD) && in_range;

  // Sweep position bookkeeping
  assign issue1     = (state_q == ST_SWEEP) && ph_q;
  assign last_cell  = (r_q == RW'(MAX_N - 1)) && (c_q == RW'(MAX_N - 1));
  assign pipe_empty = !p1_v_q && !s1_v_q && !s2_v_q;

  always_comb begin
    nbr.in_grid = (NW'(r_q) < n_act) && (NW'(c_q) < n_act);
    nbr.up      = (r_q != '0);
    nbr.down    = (NW'(r_q) + NW'(1)) < n_act;
    nbr.left    = (c_q != '0);
    nbr.right   = (NW'(c_q) + NW'(1)) < n_act;
  end

  // Read addresses: up/down in phase 0, self/right in phase 1, host address outside a sweep
  always_comb begin
    if (state_q == ST_SWEEP) begin
      if (!ph_q) begin
        raddr0 = {r_q - RW'(1), c_q};
        raddr1 = {r_q + RW'(1), c_q};
      end else begin
        raddr0 = {r_q, c_q};
        raddr1 = {r_q, c_q + RW'(1)};
      end
    end else begin
      raddr0 = io_addr;
      raddr1 = io_addr;
    end
  end

  // Steer writes: loads go to the current bank, sweep results to the other one
  assign wr_data = s2_in_q ? nv_q : s2_self_q;
  assign wr_addr = s2_v_q ? s2_addr_q : io_addr;
  assign we_a    = (load_we && !cur_q) || (s2_v_q && cur_q);
  assign we_b    = (load_we && cur_q) || (s2_v_q && !cur_q);

  jsr_bank #(.AW(AW)) u_bank_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (wr_addr),
    .wdata_i  (s2_v_q ? wr_data : req_i.value),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  jsr_bank #(.AW(AW)) u_bank_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (wr_addr),
    .wdata_i  (s2_v_q ? wr_data : req_i.value),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  assign src_rd0 = cur_q ? b_rd0 : a_rd0;
  assign src_rd1 = cur_q ? b_rd1 : a_rd1;

  // Stencil sum, border terms forced to zero
  assign sum_d = jsr_pkg::SUM_W'(src_rd0)
               + (p1_nbr_q.up    ? jsr_pkg::SUM_W'(up_q)    : '0)
               + (p1_nbr_q.down  ? jsr_pkg::SUM_W'(down_q)  : '0)
               + (p1_nbr_q.left  ? jsr_pkg::SUM_W'(left_q)  : '0)
               + (p1_nbr_q.right ? jsr_pkg::SUM_W'(src_rd1) : '0);

  // Divide by five through the reciprocal
  assign prod = PW'(sum_q) * PW'(jsr_pkg::DIV_RECIP);

  // Absolute change of an active cell
  always_comb begin
    if (!s2_in_q) begin
      diff = '0;
    end else if (nv_q > s2_self_q) begin
      diff = nv_q - s2_self_q;
    end else begin
      diff = s2_self_q - nv_q;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue1;
      s1_v_q <= p1_v_q;
      s2_v_q <= s1_v_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (issue1) begin
      p1_nbr_q  <= nbr;
      p1_addr_q <= {r_q, c_q};
      up_q      <= src_rd0;
      down_q    <= src_rd1;
    end
    if (p1_v_q) begin
      sum_q     <= sum_d;
      s1_self_q <= src_rd0;
      s1_in_q   <= p1_nbr_q.in_grid;
      s1_addr_q <= p1_addr_q;
      left_q    <= src_rd0;
    end
    if (s1_v_q) begin
      nv_q      <= prod[jsr_pkg::DIV_SHIFT +: jsr_pkg::CELL_W];
      s2_self_q <= s1_self_q;
      s2_in_q   <= s1_in_q;
      s2_addr_q <= s1_addr_q;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= jsr_pkg::GSIZE_RST;
      threshold_q <= jsr_pkg::THRESH_RST;
      max_iter_q  <= jsr_pkg::MAXIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jsr_pkg::CFG_GRID_SIZE: grid_size_q <= cfg_data_i[jsr_pkg::GSIZE_W-1:0];
        jsr_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[jsr_pkg::CELL_W-1:0];
        jsr_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[jsr_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: command decode, sweep walk, convergence check, result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      r_q        <= '0;
      c_q        <= '0;
      ph_q       <= 1'b0;
      iters_q    <= '0;
      big_q      <= '0;
      cur_q      <= 1'b0;
      done_q     <= 1'b0;
      out_rd_q   <= 1'b0;
      out_iter_q <= '0;
      out_hit_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (s2_v_q && (diff > big_q)) begin
        big_q <= diff;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            out_rd_q   <= 1'b0;
            out_iter_q <= '0;
            out_hit_q  <= 1'b0;
            unique case (req_i.mode)
              jsr_pkg::MODE_RUN: begin
                state_q <= ST_SWEEP;
                r_q     <= '0;
                c_q     <= '0;
                ph_q    <= 1'b0;
                iters_q <= '0;
                big_q   <= '0;
              end
              jsr_pkg::MODE_READ: begin
                done_q   <= 1'b1;
                out_rd_q <= in_range;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            c_q <= c_q + RW'(1);
            if (c_q == RW'(MAX_N - 1)) begin
              c_q <= '0;
              r_q <= r_q + RW'(1);
            end
            if (last_cell) begin
              state_q <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            cur_q   <= !cur_q;
            iters_q <= iters_n;
            if (big_q <= threshold_q) begin
              state_q    <= ST_IDLE;
              done_q     <= 1'b1;
              out_iter_q <= iters_n;
              out_hit_q  <= 1'b0;
            end else if (iters_n >= lim_eff) begin
              state_q    <= ST_IDLE;
              done_q     <= 1'b1;
              out_iter_q <= iters_n;
              out_hit_q  <= 1'b1;
            end else begin
              state_q <= ST_SWEEP;
              r_q     <= '0;
              c_q     <= '0;
              ph_q    <= 1'b0;
              big_q   <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Drive the result word
  assign done_o           = done_q;
  assign rsp_o.cell_value = out_rd_q ? src_rd0 : '0;
  assign rsp_o.iterations = out_iter_q;
  assign rsp_o.hit_limit  = out_hit_q;

`ifndef SYNTH
  // A result word never shows while a run is still in progress
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Sweep writes only happen inside a run
  a_wr_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> busy)
    else $error("sweep write outside a run");

  // Load, read and unused commands answer in the next cycle
  a_short_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.mode != jsr_pkg::MODE_RUN)) |=> done_o)
    else $error("missing result for a short command");

  // A run that hits the limit reports exactly the limit
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.hit_limit) |-> (rsp_o.iterations == lim_eff))
    else $error("limit flag with wrong sweep count");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Jacobi stencil relaxation block.
module tb_top;

  localparam int GRID_DIM     = 64;
  localparam int GRID_CELLS   = GRID_DIM * GRID_DIM;
  localparam int FILL_DIM     = 4;
  localparam int STENCIL_TAPS = 5;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [jsr_pkg::CELL_W-1:0] CELL_MAX = '1;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  jsr_pkg::req_t                 req_i = '0;
  logic                          done_o;
  jsr_pkg::rsp_t                 rsp_o;
  logic                          cfg_we_i = 1'b0;
  logic [jsr_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [jsr_pkg::CFG_W-1:0]     cfg_data_i = '0;

  jacobi_stencil_relaxation #(
    .MAX_N(GRID_DIM)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mirror of the grid banks and registers
  logic [jsr_pkg::CELL_W-1:0]  cells [2][GRID_CELLS];
  bit                          written [2][GRID_CELLS];
  bit                          live_bank = 1'b0;
  logic [jsr_pkg::GSIZE_W-1:0] grid_size_q = jsr_pkg::GSIZE_RST;
  logic [jsr_pkg::CELL_W-1:0]  thresh_q = jsr_pkg::THRESH_RST;
  logic [jsr_pkg::ITER_W-1:0]  maxit_q = jsr_pkg::MAXIT_RST;

  jsr_pkg::rsp_t pending_rsp [$];
  int   idle_pct = 13;
  int   n_fail = 0;
  int   n_results = 0;
  int   words_by_mode [4] = '{0, 0, 0, 0};
  int   n_sweeps = 0;
  int   n_limit_hits = 0;

  function automatic int active_dim();
    if (grid_size_q == '0) return 1;
    if (int'(grid_size_q) > GRID_DIM) return GRID_DIM;
    return int'(grid_size_q);
  endfunction

  // Cells past the active grid act as the zero border
  function automatic logic [jsr_pkg::CELL_W-1:0] stencil_tap(int b, int n, int r, int c);
    if (r < 0 || c < 0 || r >= n || c >= n) return '0;
    return cells[b][r * GRID_DIM + c];
  endfunction

  // One sweep into the other bank; returns the largest cell change
  function automatic logic [jsr_pkg::CELL_W-1:0] relax_sweep();
    int src;
    int dst;
    int n;
    logic [jsr_pkg::SUM_W-1:0]  acc;
    logic [jsr_pkg::CELL_W-1:0] self_v;
    logic [jsr_pkg::CELL_W-1:0] next_v;
    logic [jsr_pkg::CELL_W-1:0] delta;
    logic [jsr_pkg::CELL_W-1:0] peak;
    src  = int'(live_bank);
    dst  = 1 - src;
    n    = active_dim();
    peak = '0;
    for (int i = 0; i < GRID_CELLS; i++) begin
      cells[dst][i]   = cells[src][i];
      written[dst][i] = written[src][i];
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        self_v = cells[src][r * GRID_DIM + c];
        acc = jsr_pkg::SUM_W'(self_v) + jsr_pkg::SUM_W'(stencil_tap(src, n, r - 1, c))
            + jsr_pkg::SUM_W'(stencil_tap(src, n, r + 1, c))
            + jsr_pkg::SUM_W'(stencil_tap(src, n, r, c - 1))
            + jsr_pkg::SUM_W'(stencil_tap(src, n, r, c + 1));
        next_v = jsr_pkg::CELL_W'(acc / STENCIL_TAPS);
        cells[dst][r * GRID_DIM + c] = next_v;
        delta = (next_v > self_v) ? next_v - self_v : self_v - next_v;
        if (delta > peak) peak = delta;
      end
    end
    live_bank = ~live_bank;
    return peak;
  endfunction

  // Apply one accepted word to the mirror and return the result it must produce
  function automatic jsr_pkg::rsp_t predict_response(jsr_pkg::req_t w);
    jsr_pkg::rsp_t r;
    int limit;
    int sweeps;
    int idx;
    logic [jsr_pkg::CELL_W-1:0] peak;
    r   = '0;
    idx = int'(w.row) * GRID_DIM + int'(w.col);
    case (w.mode)
      jsr_pkg::MODE_LOAD: begin
        cells[live_bank][idx]   = w.value;
        written[live_bank][idx] = 1'b1;
      end
      jsr_pkg::MODE_READ: r.cell_value = cells[live_bank][idx];
      jsr_pkg::MODE_RUN: begin
        limit  = (maxit_q == '0) ? 1 : int'(maxit_q);
        sweeps = 0;
        do begin
          peak = relax_sweep();
          sweeps++;
        end while (peak > thresh_q && sweeps < limit);
        r.iterations = jsr_pkg::ITER_W'(sweeps);
        r.hit_limit  = (peak > thresh_q);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic jsr_pkg::req_t make_word(logic [1:0] mode,
                                              logic [jsr_pkg::IDX_W-1:0] row,
                                              logic [jsr_pkg::IDX_W-1:0] col,
                                              logic [jsr_pkg::CELL_W-1:0] value);
    jsr_pkg::req_t w;
    w.mode  = mode;
    w.row   = row;
    w.col   = col;
    w.value = value;
    return w;
  endfunction

  function automatic logic [jsr_pkg::CELL_W-1:0] rand_cell();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CELL_MAX;
      2:       return jsr_pkg::CELL_W'($urandom_range(255));
      default: return jsr_pkg::CELL_W'($urandom);
    endcase
  endfunction

  task automatic note_failure(string msg);
    n_fail++;
    if (n_fail <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    jsr_pkg::rsp_t want;
    if (done_o === 1'b1) begin
      n_results++;
      if (pending_rsp.size() == 0) begin
        note_failure($sformatf("unexpected word: cell_value %06h iterations %0d hit_limit %0b",
                               rsp_o.cell_value, rsp_o.iterations, rsp_o.hit_limit));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.cell_value !== want.cell_value)
          note_failure($sformatf("word %0d cell_value: expected %06h, got %06h",
                                 n_results, want.cell_value, rsp_o.cell_value));
        if (rsp_o.iterations !== want.iterations)
          note_failure($sformatf("word %0d iterations: expected %0d, got %0d",
                                 n_results, want.iterations, rsp_o.iterations));
        if (rsp_o.hit_limit !== want.hit_limit)
          note_failure($sformatf("word %0d hit_limit: expected %0b, got %0b",
                                 n_results, want.hit_limit, rsp_o.hit_limit));
      end
    end
  end

  // Offer one word, hold it until accepted, then maybe drop start and idle
  task automatic send_word(jsr_pkg::req_t w);
    jsr_pkg::rsp_t r;
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = predict_response(w);
    pending_rsp.push_back(r);
    words_by_mode[w.mode]++;
    if (w.mode == jsr_pkg::MODE_RUN) begin
      n_sweeps     += int'(r.iterations);
      n_limit_hits += int'(r.hit_limit);
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every result is in and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_config(logic [jsr_pkg::GSIZE_W-1:0] gsize,
                            logic [jsr_pkg::CELL_W-1:0] thr,
                            logic [jsr_pkg::ITER_W-1:0] maxit);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= jsr_pkg::CFG_GRID_SIZE;
    cfg_data_i <= jsr_pkg::CFG_W'(gsize);
    @(posedge clk_i);
    cfg_idx_i  <= jsr_pkg::CFG_THRESHOLD;
    cfg_data_i <= jsr_pkg::CFG_W'(thr);
    @(posedge clk_i);
    cfg_idx_i  <= jsr_pkg::CFG_MAX_ITER;
    cfg_data_i <= jsr_pkg::CFG_W'(maxit);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    grid_size_q = gsize;
    thresh_q    = thr;
    maxit_q     = maxit;
  endtask

  // Load the corner block that every later run works on, then relax it and read back three of its cells
  task automatic test_small_grid();
    logic [jsr_pkg::CELL_W-1:0] v;
    set_config(jsr_pkg::GSIZE_W'(FILL_DIM), '0, 16'd2);
    for (int i = 0; i < FILL_DIM * FILL_DIM; i++) begin
      v = (i == 0) ? CELL_MAX : (i == FILL_DIM * FILL_DIM - 1) ? '0 : rand_cell();
      send_word(make_word(jsr_pkg::MODE_LOAD, jsr_pkg::IDX_W'(i / FILL_DIM),
                          jsr_pkg::IDX_W'(i % FILL_DIM), v));
    end
    send_word(make_word(jsr_pkg::MODE_RUN, '0, '0, '0));
    send_word(make_word(jsr_pkg::MODE_READ, '0, '0, '0));
    send_word(make_word(jsr_pkg::MODE_READ, jsr_pkg::IDX_W'(FILL_DIM - 1),
                        jsr_pkg::IDX_W'(FILL_DIM - 1), '0));
    send_word(make_word(jsr_pkg::MODE_READ, '0, jsr_pkg::IDX_W'(FILL_DIM - 1), '0));
  endtask

  // Single-cell grid: outside cells are kept, unused mode writes nothing, zero limit acts as one
  task automatic test_bounds_and_unused();
    set_config(7'd1, '0, '0);
    send_word(make_word(jsr_pkg::MODE_LOAD, '0, '0, CELL_MAX));
    send_word(make_word(jsr_pkg::MODE_LOAD, '1, '1, CELL_MAX));
    send_word(make_word(MODE_UNUSED, '1, '1, '0));
    send_word(make_word(jsr_pkg::MODE_READ, '1, '1, '0));
    send_word(make_word(jsr_pkg::MODE_RUN, '1, '1, CELL_MAX));
    send_word(make_word(jsr_pkg::MODE_READ, '0, '0, '0));
    send_word(make_word(jsr_pkg::MODE_READ, '1, '1, '0));
    send_word(make_word(jsr_pkg::MODE_READ, '0, 6'd1, '0));
  endtask

  // Zero grid size acts as one; widest threshold stops after one sweep
  task automatic test_grid_size_zero();
    set_config('0, CELL_MAX, 16'hFFFF);
    send_word(make_word(jsr_pkg::MODE_RUN, '0, '0, '0));
    send_word(make_word(jsr_pkg::MODE_READ, '0, '0, '0));
    send_word(make_word(jsr_pkg::MODE_READ, 6'd1, '0, '0));
  endtask

  // Convergence on the last allowed sweep, at once on a still grid, and at the limit
  task automatic test_convergence();
    set_config(7'd1, 24'd1, 16'd2);
    send_word(make_word(jsr_pkg::MODE_LOAD, '0, '0, 24'd5));
    send_word(make_word(jsr_pkg::MODE_RUN, '0, '0, '0));
    send_word(make_word(jsr_pkg::MODE_READ, '0, '0, '0));
    set_config(7'd2, '0, 16'd1);
    for (int i = 0; i < 4; i++)
      send_word(make_word(jsr_pkg::MODE_LOAD, jsr_pkg::IDX_W'(i / 2),
                          jsr_pkg::IDX_W'(i % 2), '0));
    send_word(make_word(jsr_pkg::MODE_RUN, '0, '0, '0));
    set_config(7'd2, '0, 16'd3);
    send_word(make_word(jsr_pkg::MODE_LOAD, 6'd1, 6'd1, CELL_MAX));
    send_word(make_word(jsr_pkg::MODE_RUN, '0, '0, '0));
    send_word(make_word(jsr_pkg::MODE_READ, 6'd1, 6'd1, '0));
  endtask

  // Keep runs short and inside the loaded corner block
  task automatic random_config();
    logic [jsr_pkg::GSIZE_W-1:0] gsize;
    logic [jsr_pkg::CELL_W-1:0]  thr;
    logic [jsr_pkg::ITER_W-1:0]  maxit;
    case ($urandom_range(4))
      0:       gsize = '0;
      default: gsize = jsr_pkg::GSIZE_W'($urandom_range(1, FILL_DIM));
    endcase
    case ($urandom_range(3))
      0:       thr = '0;
      1:       thr = jsr_pkg::CELL_W'($urandom_range(16'hFFFF));
      2:       thr = jsr_pkg::CELL_W'($urandom);
      default: thr = CELL_MAX;
    endcase
    maxit = jsr_pkg::ITER_W'($urandom_range(3));
    if ($urandom_range(4) == 0) begin
      maxit = jsr_pkg::ITER_W'($urandom);
      thr   = CELL_MAX;
    end
    set_config(gsize, thr, maxit);
  endtask

  // Mostly loads and reads inside the active grid with runs between them
  function automatic jsr_pkg::req_t random_word();
    int n;
    int pick;
    int r;
    int c;
    n    = active_dim();
    pick = $urandom_range(99);
    r    = $urandom_range(GRID_DIM - 1);
    c    = $urandom_range(GRID_DIM - 1);
    // Read only cells that hold loaded data
    if (!written[live_bank][r * GRID_DIM + c]) begin
      r = $urandom_range(FILL_DIM - 1);
      c = $urandom_range(FILL_DIM - 1);
    end
    if (pick < 35)
      return make_word(jsr_pkg::MODE_LOAD, jsr_pkg::IDX_W'($urandom_range(n - 1)),
                       jsr_pkg::IDX_W'($urandom_range(n - 1)), rand_cell());
    if (pick < 45)
      return make_word(jsr_pkg::MODE_LOAD, jsr_pkg::IDX_W'($urandom),
                       jsr_pkg::IDX_W'($urandom), rand_cell());
    if (pick < 70)
      return make_word(jsr_pkg::MODE_READ, jsr_pkg::IDX_W'($urandom_range(n - 1)),
                       jsr_pkg::IDX_W'($urandom_range(n - 1)), jsr_pkg::CELL_W'($urandom));
    if (pick < 80)
      return make_word(jsr_pkg::MODE_READ, jsr_pkg::IDX_W'(r), jsr_pkg::IDX_W'(c),
                       jsr_pkg::CELL_W'($urandom));
    if (pick < 92)
      return make_word(jsr_pkg::MODE_RUN, jsr_pkg::IDX_W'($urandom),
                       jsr_pkg::IDX_W'($urandom), jsr_pkg::CELL_W'($urandom));
    return make_word(MODE_UNUSED, jsr_pkg::IDX_W'($urandom), jsr_pkg::IDX_W'($urandom),
                     jsr_pkg::CELL_W'($urandom));
  endfunction

  task automatic test_random_traffic(int pct, int words);
    idle_pct = pct;
    for (int blk = 0; blk < 3; blk++) begin
      random_config();
      for (int k = 0; k < words / 3; k++) send_word(random_word());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_grid();
    test_bounds_and_unused();
    test_grid_size_zero();
    test_convergence();
    test_random_traffic(13, 18);
    test_random_traffic(66, 18);
    test_random_traffic(0, 18);
    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d loads, %0d reads, %0d runs (%0d sweeps, %0d at the limit), %0d unused",
             words_by_mode[jsr_pkg::MODE_LOAD], words_by_mode[jsr_pkg::MODE_READ],
             words_by_mode[jsr_pkg::MODE_RUN], n_sweeps, n_limit_hits,
             words_by_mode[MODE_UNUSED]);
    $display("Checked %0d result words, %0d mismatches", n_results, n_fail);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest run that this bench issues
  initial begin
    #250_000_000;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
